// ===== rtl/core/hrt_pkg.sv =====
// Shared command, status and width constants for the reload timer.
`timescale 1ns / 1ps

package hrt_pkg;

	localparam int STAMP_WIDTH = 32;
	localparam int ACC_WIDTH   = 32;
	localparam int TPM_WIDTH   = 24;
	localparam int RELOAD_W    = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	// Command codes
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_STOP  = 2'd2;
	localparam logic [1:0] FUNC_RESET = 2'd3;

	// Result status codes
	localparam logic [1:0] STATUS_IDLE    = 2'd0;
	localparam logic [1:0] STATUS_RUN     = 2'd1;
	localparam logic [1:0] STATUS_EXPIRED = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_MS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_HOURS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_MINUTES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_SECONDS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_MILLIS  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELOAD_MODE    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RELOAD_COUNT   = 3'd6;

	localparam logic [TPM_WIDTH-1:0] TPM_RESET      = 24'd1000;
	localparam logic [RELOAD_W-1:0]  RELOAD_ENDLESS = 17'h1FFFF;

	localparam logic [9:0] MILLIS_MAX = 10'd999;
	localparam logic [5:0] SIXTY_MAX  = 6'd59;

	// Time of day as hours, minutes, seconds, milliseconds
	typedef struct packed {
		logic [4:0] hours;
		logic [5:0] minutes;
		logic [5:0] seconds;
		logic [9:0] millis;
	} hms_time_t;

endpackage

// ===== rtl/core/hms_reload_timer.sv =====
// Periodic reload timer counting hours, minutes, seconds and milliseconds.
`timescale 1ns / 1ps

// Each command beat yields one result beat. Start, stop and reset go from
// acceptance straight to the done state, as does a tick on a stopped timer
// or a tick whose stamp went backwards. A running tick passes through the step
// state first, one step per elapsed millisecond, then goes to the done state.
// A single shared subtract-and-compare unit takes ticks_per_ms out of the
// accumulator and advances the count by one millisecond per cycle. It stops
// early on expiry. in_stall stays high while a command is in progress and
// while its result waits for a free output register. The next command is
// accepted in the cycle after the result is loaded. The output register holds
// the result until it is taken.
module hms_reload_timer import hrt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               func,
	input  logic [STAMP_WIDTH-1:0]   now_stamp,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic                     running,
	output logic signed [RELOAD_W-1:0] reloads_left,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_STEP = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                state_q;
	logic [1:0]                res_status_q;

	logic [TPM_WIDTH-1:0]      tpm_q;
	hms_time_t                 target_q;
	logic                      reload_mode_q;
	logic [RELOAD_W-1:0]       reload_count_q;

	logic                      running_q;
	hms_time_t                 count_q;
	logic [ACC_WIDTH-1:0]      acc_q;
	logic [STAMP_WIDTH-1:0]    last_q;
	logic [RELOAD_W-1:0]       reload_left_q;

	logic                      out_valid_q;
	logic [1:0]                out_status_q;
	logic                      out_running_q;
	logic [RELOAD_W-1:0]       out_reloads_q;

	logic                      in_beat;
	logic                      out_free;
	logic [TPM_WIDTH-1:0]      tpm_eff;
	logic [ACC_WIDTH:0]        acc_sum;
	logic [ACC_WIDTH-1:0]      acc_sat;
	logic                      stamp_fwd;
	logic                      step_go;
	hms_time_t                 count_inc;
	logic                      tgt_carry_ms;
	logic                      tgt_carry_sec;
	logic                      tgt_carry_min;
	logic [6:0]                tgt_sec_sum;
	logic [6:0]                tgt_min_sum;
	logic [5:0]                tgt_hours_sum;
	hms_time_t                 target_norm;
	logic                      target_ok;
	logic                      expire;
	logic                      reload_avail;

	assign in_beat  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign running      = out_running_q;
	assign reloads_left = out_reloads_q;

	// Treat a zero rate as one tick per millisecond
	assign tpm_eff = (tpm_q == '0) ? TPM_WIDTH'(1) : tpm_q;

	// Add elapsed ticks, saturating at the accumulator limit
	assign stamp_fwd = (now_stamp >= last_q);
	assign acc_sum   = {1'b0, acc_q} + {1'b0, ACC_WIDTH'(now_stamp - last_q)};
	assign acc_sat   = acc_sum[ACC_WIDTH] ? '1 : acc_sum[ACC_WIDTH-1:0];

	// Shared unit: one millisecond step while the accumulator exceeds the rate
	assign step_go = (acc_q > {{(ACC_WIDTH-TPM_WIDTH){1'b0}}, tpm_eff});

	// Advance the cascaded count by one millisecond
	always_comb begin
		count_inc = count_q;
		if (count_q.millis == MILLIS_MAX) begin
			count_inc.millis = '0;
			if (count_q.seconds == SIXTY_MAX) begin
				count_inc.seconds = '0;
				if (count_q.minutes == SIXTY_MAX) begin
					count_inc.minutes = '0;
					count_inc.hours   = count_q.hours + 5'd1;
				end else begin
					count_inc.minutes = count_q.minutes + 6'd1;
				end
			end else begin
				count_inc.seconds = count_q.seconds + 6'd1;
			end
		end else begin
			count_inc.millis = count_q.millis + 10'd1;
		end
	end

	// Fold out-of-range target fields into the next unit up
	always_comb begin
		target_norm  = target_q;
		tgt_carry_ms = (target_q.millis > MILLIS_MAX);
		if (tgt_carry_ms) begin
			target_norm.millis = target_q.millis - (MILLIS_MAX + 10'd1);
		end
		tgt_sec_sum   = {1'b0, target_q.seconds} + {6'd0, tgt_carry_ms};
		tgt_carry_sec = (tgt_sec_sum > {1'b0, SIXTY_MAX});
		target_norm.seconds = tgt_carry_sec ? (tgt_sec_sum[5:0] - (SIXTY_MAX + 6'd1)) :
			tgt_sec_sum[5:0];
		tgt_min_sum   = {1'b0, target_q.minutes} + {6'd0, tgt_carry_sec};
		tgt_carry_min = (tgt_min_sum > {1'b0, SIXTY_MAX});
		target_norm.minutes = tgt_carry_min ? (tgt_min_sum[5:0] - (SIXTY_MAX + 6'd1)) :
			tgt_min_sum[5:0];
		tgt_hours_sum     = {1'b0, target_q.hours} + {5'd0, tgt_carry_min};
		target_norm.hours = tgt_hours_sum[4:0];
	end

	// Compare the stepped count as one whole time; a target past the count
	// range never expires
	assign target_ok = !tgt_hours_sum[5];
	assign expire = target_ok && (count_inc >= target_norm);
	assign reload_avail = (!reload_left_q[RELOAD_W-1] && (reload_left_q != '0)) ||
		(reload_left_q == RELOAD_ENDLESS);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpm_q          <= TPM_RESET;
			target_q       <= '0;
			reload_mode_q  <= 1'b0;
			reload_count_q <= RELOAD_ENDLESS;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_TICKS_PER_MS:   tpm_q            <= cfg_data;
				REG_TARGET_HOURS:   target_q.hours   <= cfg_data[4:0];
				REG_TARGET_MINUTES: target_q.minutes <= cfg_data[5:0];
				REG_TARGET_SECONDS: target_q.seconds <= cfg_data[5:0];
				REG_TARGET_MILLIS:  target_q.millis  <= cfg_data[9:0];
				REG_RELOAD_MODE:    reload_mode_q    <= cfg_data[0];
				REG_RELOAD_COUNT:   reload_count_q   <= cfg_data[RELOAD_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer and timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			res_status_q  <= STATUS_IDLE;
			running_q     <= 1'b0;
			count_q       <= '0;
			acc_q         <= '0;
			last_q        <= '0;
			reload_left_q <= RELOAD_ENDLESS;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						state_q <= (func == FUNC_TICK && running_q && stamp_fwd) ?
							ST_STEP : ST_DONE;
						case (func)
							FUNC_TICK: begin
								last_q       <= now_stamp;
								res_status_q <= running_q ? STATUS_RUN : STATUS_IDLE;
								if (running_q && stamp_fwd) begin
									acc_q <= acc_sat;
								end
							end
							FUNC_START: begin
								last_q       <= now_stamp;
								running_q    <= 1'b1;
								res_status_q <= STATUS_RUN;
							end
							FUNC_STOP: begin
								running_q    <= 1'b0;
								res_status_q <= STATUS_IDLE;
							end
							default: begin
								count_q       <= '0;
								reload_left_q <= reload_count_q;
								res_status_q  <= running_q ? STATUS_RUN : STATUS_IDLE;
							end
						endcase
					end
				end
				ST_STEP: begin
					if (!step_go) begin
						res_status_q <= STATUS_RUN;
						state_q      <= ST_DONE;
					end else if (expire) begin
						res_status_q <= STATUS_EXPIRED;
						state_q      <= ST_DONE;
						if (reload_mode_q && reload_avail) begin
							count_q   <= '0;
							acc_q     <= '0;
							running_q <= 1'b1;
							if (reload_left_q != RELOAD_ENDLESS) begin
								reload_left_q <= reload_left_q - RELOAD_W'(1);
							end
						end else begin
							count_q   <= count_inc;
							acc_q     <= acc_q - {{(ACC_WIDTH-TPM_WIDTH){1'b0}}, tpm_eff};
							running_q <= 1'b0;
						end
					end else begin
						count_q <= count_inc;
						acc_q   <= acc_q - {{(ACC_WIDTH-TPM_WIDTH){1'b0}}, tpm_eff};
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register: load the finished result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_status_q  <= res_status_q;
			out_running_q <= running_q;
			out_reloads_q <= reload_left_q;
		end
	end

	// Stepping only ever happens on a running timer
	a_step_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> running_q)
		else $error("millisecond step on a stopped timer");

	// A not-running status always reports a stopped timer
	a_idle_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STATUS_IDLE) |-> !out_running_q)
		else $error("idle status with timer running");

	// A running status always reports a running timer
	a_run_running: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STATUS_RUN) |-> out_running_q)
		else $error("running status with timer stopped");

	// Single-shot expiry always stops the timer
	a_single_shot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q == STATUS_EXPIRED && !reload_mode_q) |-> !out_running_q)
		else $error("single-shot expiry left timer running");

endmodule

// ===== tb/sv/hms_reload_timer_tb.sv =====
// Testbench for the reload timer: command beats checked against a behavioral timer model.
`timescale 1ns / 1ps

module hms_reload_timer_tb;
	import hrt_pkg::*;

	localparam longint unsigned MS_SEC     = 1000;
	localparam longint unsigned MS_MIN     = 60000;
	localparam longint unsigned MS_HOUR    = 3600000;
	localparam longint unsigned COUNT_WRAP = 32 * MS_HOUR;
	localparam longint unsigned ACC_SAT    = 64'hFFFF_FFFF;
	localparam int MAX_STEPS    = 24;     // ms steps per ordinary random tick
	localparam int MAX_BURST    = 4096;   // ms steps any single tick may take
	localparam int DRAIN_RATIO  = 1024;
	localparam int HOLD_CYCLES  = 400;
	localparam int CHUNK_ITEMS  = 68;
	localparam int CYCLE_LIMIT  = 40000000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [1:0]                 status;
		logic                       running;
		logic signed [RELOAD_W-1:0] reloads;
	} timer_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [1:0]                 func = FUNC_TICK;
	logic [STAMP_WIDTH-1:0]     now_stamp = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [1:0]                 status;
	logic                       running;
	logic signed [RELOAD_W-1:0] reloads_left;
	logic                       cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]       cfg_index = '0;
	logic [CFG_DATA_W-1:0]      cfg_data = '0;

	// Model configuration
	logic [TPM_WIDTH-1:0]       tpm_r;
	logic [4:0]                 tgt_hours_r;
	logic [5:0]                 tgt_min_r;
	logic [5:0]                 tgt_sec_r;
	logic [9:0]                 tgt_ms_r;
	logic                       mode_r;
	logic signed [RELOAD_W-1:0] reload_cfg_r;

	// Model state
	bit                         run_m;
	longint unsigned            count_m;
	longint unsigned            acc_m;
	longint unsigned            last_m;
	logic signed [RELOAD_W-1:0] reload_left_m;

	timer_result_t expected_results[$];
	int            mismatch_count = 0;
	int            cycle_count = 0;
	int            send_idle_pct = 0;
	int            recv_stall_pct = 0;
	bit            receiver_hold = 1'b0;
	event          hold_go;

	hms_reload_timer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.now_stamp    (now_stamp),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.running      (running),
		.reloads_left (reloads_left),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL hms_reload_timer");
			$finish;
		end
	end

	// Hold off the receiver for a fixed stretch on request
	initial forever begin
		@(hold_go);
		receiver_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		receiver_hold = 1'b0;
	end

	function automatic longint unsigned tick_span(input logic [TPM_WIDTH-1:0] t);
		return (t == 0) ? 1 : t;
	endfunction

	function automatic longint unsigned target_ms();
		return tgt_hours_r * MS_HOUR + tgt_min_r * MS_MIN + tgt_sec_r * MS_SEC + tgt_ms_r;
	endfunction

	task automatic reset_model();
		tpm_r = TPM_RESET;
		tgt_hours_r = '0;
		tgt_min_r = '0;
		tgt_sec_r = '0;
		tgt_ms_r = '0;
		mode_r = 1'b0;
		reload_cfg_r = RELOAD_ENDLESS;
		run_m = 1'b0;
		count_m = 0;
		acc_m = 0;
		last_m = 0;
		reload_left_m = RELOAD_ENDLESS;
	endtask

	// Advance the count for one running tick; return 1 on expiry
	function automatic bit advance_count(input longint unsigned now);
		longint unsigned sum, step, k, t, s0, j;
		if (now < last_m)
			return 1'b0;
		sum = acc_m + (now - last_m);
		if (sum > ACC_SAT)
			sum = ACC_SAT;
		acc_m = sum;
		step = tick_span(tpm_r);
		k = (sum == 0) ? 0 : (sum - 1) / step;
		if (k == 0)
			return 1'b0;
		t = target_ms();
		if (t < COUNT_WRAP) begin
			s0 = (count_m + 1) % COUNT_WRAP;
			j = (s0 >= t) ? 1 : 1 + (t - s0);
			if (j <= k) begin
				count_m = (count_m + j) % COUNT_WRAP;
				acc_m = sum - j * step;
				if (!mode_r) begin
					run_m = 1'b0;
				end else if (reload_left_m > 0 || reload_left_m == -1) begin
					count_m = 0;
					acc_m = 0;
					if (reload_left_m > 0)
						reload_left_m = reload_left_m - 1;
					run_m = 1'b1;
				end else begin
					run_m = 1'b0;
				end
				return 1'b1;
			end
		end
		count_m = (count_m + k % COUNT_WRAP) % COUNT_WRAP;
		acc_m = sum - k * step;
		return 1'b0;
	endfunction

	function automatic timer_result_t predict_command(input logic [1:0] f,
			input logic [STAMP_WIDTH-1:0] s);
		timer_result_t r;
		case (f)
			FUNC_TICK: begin
				if (run_m)
					r.status = advance_count(s) ? STATUS_EXPIRED : STATUS_RUN;
				else
					r.status = STATUS_IDLE;
				last_m = s;
			end
			FUNC_START: begin
				last_m = s;
				run_m = 1'b1;
				r.status = STATUS_RUN;
			end
			FUNC_STOP: begin
				run_m = 1'b0;
				r.status = STATUS_IDLE;
			end
			default: begin
				count_m = 0;
				reload_left_m = reload_cfg_r;
				r.status = run_m ? STATUS_RUN : STATUS_IDLE;
			end
		endcase
		r.running = run_m;
		r.reloads = reload_left_m;
		return r;
	endfunction

	// Compare one result beat with the oldest prediction
	task automatic check_result();
		timer_result_t want;
		if (expected_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected result beat: status %0d running %0b reloads_left %0d",
					status, running, reloads_left);
			return;
		end
		want = expected_results.pop_front();
		if (status !== want.status || running !== want.running ||
				reloads_left !== want.reloads) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("result mismatch (exp/got): status %0d/%0d running %0b/%0b reloads_left %0d/%0d",
					want.status, status, want.running, running,
					$signed(want.reloads), reloads_left);
		end
	endtask

	// Take result beats and drive the receiver stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result();
		if (receiver_hold)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Offer one command beat, with random gaps ahead of it
	task automatic send_command(input logic [1:0] f, input logic [STAMP_WIDTH-1:0] s);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		now_stamp <= s;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_results.push_back(predict_command(f, s));
	endtask

	// Drop valid and wait for every outstanding result
	task automatic quiesce();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_TICKS_PER_MS:   tpm_r = val;
			REG_TARGET_HOURS:   tgt_hours_r = val[4:0];
			REG_TARGET_MINUTES: tgt_min_r = val[5:0];
			REG_TARGET_SECONDS: tgt_sec_r = val[5:0];
			REG_TARGET_MILLIS:  tgt_ms_r = val[9:0];
			REG_RELOAD_MODE:    mode_r = val[0];
			REG_RELOAD_COUNT:   reload_cfg_r = val[RELOAD_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [TPM_WIDTH-1:0] tpm, input logic [4:0] h,
			input logic [5:0] m, input logic [5:0] sec, input logic [9:0] ms,
			input logic mode, input logic signed [RELOAD_W-1:0] cnt);
		write_reg(REG_TICKS_PER_MS, tpm);
		write_reg(REG_TARGET_HOURS, h);
		write_reg(REG_TARGET_MINUTES, m);
		write_reg(REG_TARGET_SECONDS, sec);
		write_reg(REG_TARGET_MILLIS, ms);
		write_reg(REG_RELOAD_MODE, mode);
		write_reg(REG_RELOAD_COUNT, {{(CFG_DATA_W-RELOAD_W){1'b0}}, cnt});
		cfg_wr_en <= 1'b0;
	endtask

	// Reprogram while idle; clear a large leftover accumulator first so a
	// smaller ticks_per_ms cannot turn it into a huge step burst
	task automatic apply_config(input logic [TPM_WIDTH-1:0] tpm, input logic [4:0] h,
			input logic [5:0] m, input logic [5:0] sec, input logic [9:0] ms,
			input logic mode, input logic signed [RELOAD_W-1:0] cnt);
		quiesce();
		if (acc_m > tick_span(tpm) * DRAIN_RATIO) begin
			write_all(24'd1, 5'd0, 6'd0, 6'd0, 10'd0, 1'b1, RELOAD_ENDLESS);
			send_command(FUNC_RESET, last_m[31:0]);
			send_command(FUNC_START, last_m[31:0]);
			send_command(FUNC_TICK, last_m[31:0]);
			send_command(FUNC_STOP, last_m[31:0]);
			quiesce();
		end
		write_all(tpm, h, m, sec, ms, mode, cnt);
	endtask

	// Pick a stamp: mostly a short step forward, sometimes backward or anywhere
	function automatic logic [31:0] pick_stamp(input logic [1:0] f);
		longint unsigned step, cand;
		int roll;
		step = tick_span(tpm_r);
		roll = $urandom_range(99);
		if (roll < 12)
			cand = $urandom;
		else if (roll < 18)
			cand = (last_m == 0) ? 0 : $urandom_range(32'(last_m - 1));
		else
			cand = last_m + step * $urandom_range(MAX_STEPS) + $urandom_range(32'(step - 1));
		cand = cand & ACC_SAT;
		// Keep any running tick to a bounded number of ms steps
		if (f == FUNC_TICK && run_m && cand >= last_m &&
				(acc_m + cand - last_m) / step > MAX_BURST)
			cand = last_m;
		return cand[31:0];
	endfunction

	task automatic random_command();
		int roll;
		logic [1:0] f;
		roll = $urandom_range(99);
		if (run_m)
			f = (roll < 82) ? FUNC_TICK : (roll < 88) ? FUNC_START :
				(roll < 93) ? FUNC_STOP : FUNC_RESET;
		else
			f = (roll < 45) ? FUNC_START : (roll < 80) ? FUNC_TICK :
				(roll < 90) ? FUNC_RESET : FUNC_STOP;
		send_command(f, pick_stamp(f));
	endtask

	task automatic test_idle_commands();
		send_command(FUNC_TICK, 32'hFFFF_FFFF);
		send_command(FUNC_STOP, 32'h0);
		send_command(FUNC_RESET, 32'h5A5A_5A5A);
	endtask

	// Expire once, stop, then expire again at the first step after restart
	task automatic test_single_shot();
		apply_config(24'd1000, 5'd0, 6'd0, 6'd0, 10'd2, 1'b0, RELOAD_ENDLESS);
		send_command(FUNC_START, 32'd100);
		send_command(FUNC_TICK, 32'd1100);
		send_command(FUNC_TICK, 32'd3101);
		send_command(FUNC_TICK, 32'd5000);
		send_command(FUNC_START, 32'd5000);
		send_command(FUNC_TICK, 32'd5000);
	endtask

	task automatic test_stamp_backwards();
		send_command(FUNC_START, 32'hFFFF_0000);
		send_command(FUNC_TICK, 32'h0000_0010);
		send_command(FUNC_STOP, 32'h0000_0020);
	endtask

	// Restart keeps the accumulator, so a full-range jump overflows it
	task automatic test_accumulator_saturation();
		apply_config(24'hFF_FFFF, 5'd31, 6'd63, 6'd0, 10'd0, 1'b0, RELOAD_ENDLESS);
		send_command(FUNC_START, 32'h0);
		send_command(FUNC_TICK, 32'h00F0_0000);
		send_command(FUNC_START, 32'h0);
		send_command(FUNC_TICK, 32'hFFFF_FFFF);
		send_command(FUNC_STOP, 32'h0);
	endtask

	// One reload left: restart once, then stop on the next expiry
	task automatic test_reload_modes();
		apply_config(24'd1, 5'd0, 6'd0, 6'd0, 10'd5, 1'b1, 17'sd1);
		send_command(FUNC_RESET, 32'h0);
		send_command(FUNC_START, 32'h0);
		send_command(FUNC_TICK, 32'd20);
		send_command(FUNC_TICK, 32'd40);
	endtask

	// Zero ticks_per_ms, most negative reload count, unused index
	task automatic test_config_extremes();
		apply_config(24'd0, 5'd23, 6'd59, 6'd63, 10'd1023, 1'b1, -17'sd65536);
		@(posedge clk);
		write_reg(REG_UNUSED, 24'hFF_FFFF);
		cfg_wr_en <= 1'b0;
		send_command(FUNC_RESET, 32'h0);
		send_command(FUNC_START, 32'h0);
		send_command(FUNC_TICK, 32'd50);
	endtask

	// Walk each idling pattern over one configuration
	task automatic random_phase();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (CHUNK_ITEMS) random_command();
		send_idle_pct = 54;
		repeat (CHUNK_ITEMS) random_command();
		send_idle_pct = 0;
		recv_stall_pct = 54;
		repeat (CHUNK_ITEMS) random_command();
		send_idle_pct = 29;
		recv_stall_pct = 29;
		repeat (CHUNK_ITEMS) random_command();
	endtask

	task automatic test_random_traffic();
		apply_config(24'd1, 5'd0, 6'd0, 6'd0, 10'd50, 1'b1, RELOAD_ENDLESS);
		random_phase();
		apply_config(24'd1000, 5'd0, 6'd0, 6'd0, 10'd137, 1'b0, RELOAD_ENDLESS);
		random_phase();
		apply_config(24'hFF_FFFF, 5'd0, 6'd0, 6'd0, 10'd3, 1'b1, 17'sd5);
		random_phase();
		apply_config(24'd7, 5'd0, 6'd0, 6'd1, 10'd20, 1'b1, 17'sd65535);
		random_phase();
		apply_config(24'd0, 5'd0, 6'd0, 6'd0, 10'd0, 1'b1, 17'sd0);
		random_phase();
		apply_config(24'd300, 5'd0, 6'd0, 6'd0, 10'd90, 1'b1, 17'sd3);
		random_phase();
	endtask

	// Stall the output long enough that the input backs up
	task automatic test_receiver_holdoff();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		-> hold_go;
		repeat (30) random_command();
	endtask

	task automatic test_sender_pause();
		send_idle_pct = 29;
		recv_stall_pct = 29;
		repeat (20) random_command();
		quiesce();
		repeat (20) random_command();
	endtask

	initial begin
		reset_model();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_commands();
		test_single_shot();
		test_stamp_backwards();
		test_accumulator_saturation();
		test_reload_modes();
		test_config_extremes();
		test_random_traffic();
		test_receiver_holdoff();
		test_sender_pause();
		quiesce();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("PASS hms_reload_timer");
		else
			$display("FAIL hms_reload_timer");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/hrt_pkg.sv
rtl/core/hms_reload_timer.sv
tb/sv/hms_reload_timer_tb.sv
